// ===== src/sbda_pkg.sv =====
`default_nettype none

package sbda_pkg;

    localparam int INT_W          = 64;
    localparam int DIGITS         = 20;
    localparam int BCD_W          = DIGITS * 4;
    localparam int IDX_W          = $clog2(DIGITS);
    localparam int BITS_PER_STEP  = 4;
    localparam int STEPS          = INT_W / BITS_PER_STEP;
    localparam int STEP_CNT_W     = $clog2(STEPS);
    localparam int FIFO_DEPTH     = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Classified item: sign and unsigned magnitude.
    typedef struct packed {
        logic             neg;
        logic [INT_W-1:0] mag;
    } qentry_t;

    // Finished conversion: sign and packed BCD digits, least significant lowest.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } conv_t;

endpackage

`default_nettype wire

// ===== src/sbda_front.sv =====
`default_nettype none

module sbda_front (
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [63:0]             s_axis_tdata,
    input  wire logic                    q_full,
    output logic                         q_push,
    output sbda_pkg::qentry_t            q_entry
);
    import sbda_pkg::*;

    logic neg;

    // The magnitude is a plain unsigned negation, so the most negative value
    // comes out as 2^63 without overflow.
    assign neg            = s_axis_tdata[INT_W-1];
    assign q_entry.neg    = neg;
    assign q_entry.mag    = neg ? (~s_axis_tdata + INT_W'(1)) : s_axis_tdata;
    assign s_axis_tready  = !q_full;
    assign q_push         = s_axis_tvalid && !q_full;

endmodule

`default_nettype wire

// ===== src/sbda_fifo.sv =====
`default_nettype none

module sbda_fifo #(
    parameter int DEPTH = sbda_pkg::FIFO_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire sbda_pkg::qentry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output sbda_pkg::qentry_t       head
);
    import sbda_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/sbda_conv.sv =====
`default_nettype none

module sbda_conv (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire sbda_pkg::qentry_t  q_head,
    output logic                    q_pop,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output sbda_pkg::conv_t         res
);
    import sbda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [STEP_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [INT_W-1:0]       mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       work_bcd;
    logic [INT_W-1:0]       work_mag;

    // Shift-and-add-3 conversion, several binary bits per cycle, most
    // significant bit first.
    always_comb begin
        work_bcd = bcd_reg;
        work_mag = mag_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (work_bcd[d*4 +: 4] >= 4'd5) begin
                    work_bcd[d*4 +: 4] = work_bcd[d*4 +: 4] + 4'd3;
                end
            end
            work_bcd = {work_bcd[BCD_W-2:0], work_mag[INT_W-1]};
            work_mag = {work_mag[INT_W-2:0], 1'b0};
        end
    end

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign res_valid = (state_reg == ST_DONE);
    assign res.neg   = neg_reg;
    assign res.bcd   = bcd_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    neg_next   = q_head.neg;
                    mag_next   = q_head.mag;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                mag_next = work_mag;
                bcd_next = work_bcd;
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

endmodule

`default_nettype wire

// ===== src/sbda_emit.sv =====
`default_nettype none

module sbda_emit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               res_valid,
    output logic                    res_ready,
    input  wire sbda_pkg::conv_t    res,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [7:0]              m_axis_tdata,
    output logic                    m_axis_tlast
);
    import sbda_pkg::*;

    logic               busy_reg, busy_next;
    logic               sign_reg, sign_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               ovalid_reg, ovalid_next;
    logic [7:0]         ochar_reg, ochar_next;
    logic               olast_reg, olast_next;
    logic               advance;
    logic [IDX_W-1:0]   top_idx;
    logic [3:0]         digit;

    // Position of the most significant non-zero digit; zero gives position
    // nought, so a zero input still prints one digit.
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (res.bcd[d*4 +: 4] != 4'd0) begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign digit     = bcd_reg[idx_reg*4 +: 4];
    assign advance   = !ovalid_reg || m_axis_tready;
    assign res_ready = !busy_reg;

    always_comb begin
        busy_next   = busy_reg;
        sign_next   = sign_reg;
        idx_next    = idx_reg;
        bcd_next    = bcd_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        if (busy_reg) begin
            if (advance) begin
                ovalid_next = 1'b1;
                if (sign_reg) begin
                    // A negative number always has digits after the sign.
                    ochar_next = CHAR_MINUS;
                    olast_next = 1'b0;
                    sign_next  = 1'b0;
                end else begin
                    ochar_next = CHAR_ZERO + {4'd0, digit};
                    olast_next = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        busy_next = 1'b0;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
        end else if (res_valid) begin
            busy_next = 1'b1;
            sign_next = res.neg;
            idx_next  = top_idx;
            bcd_next  = res.bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sign_reg  <= sign_next;
        idx_reg   <= idx_next;
        bcd_reg   <= bcd_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

// ===== src/signed_binary_to_decimal_ascii.sv =====
`default_nettype none

// Channel   Direction  Ports                       Contents
// s_axis    in         tvalid tready tdata[63:0]   signed value
// m_axis    out        tvalid tready tdata[7:0]    ASCII character, tlast on the final one
//
// The converter runs a shift-and-add-3 pass over 4 bits a cycle.
// The character stage then loads the result and emits one character a cycle while m_axis
// is ready; the converter works on the next item while the character stage emits text.
// Reset (aresetn low at a clock edge) empties the queue and drops any text in flight.
// A stall on m_axis holds the output register; input transfers continue until the
// queue of FIFO_DEPTH items in front of the converter is full.

module signed_binary_to_decimal_ascii #(
    parameter int FIFO_DEPTH = sbda_pkg::FIFO_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [63:0]    s_axis_tdata,   // [63:0] value
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] out_char
    output logic                m_axis_tlast
);
    import sbda_pkg::*;

    logic       q_full, q_push, q_valid, q_pop;
    qentry_t    q_entry, q_head;
    logic       res_valid, res_ready;
    conv_t      res;

    sbda_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    sbda_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    sbda_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sbda_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/signed_binary_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_tb;

    localparam logic [7:0] ASCII_ZERO      = 8'd48;
    localparam logic [7:0] ASCII_MINUS     = 8'd45;
    localparam int         RANDOM_VALUES   = 198;
    localparam int         QUIET_TAIL      = 40;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         MAX_REPORTED    = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    // Holds the characters still owed by the block, oldest first.
    class decimal_text_scoreboard;
        text_char_t expected_chars[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        function void note_value(logic [63:0] value);
            logic [63:0] mag;
            logic [3:0]  digit_q[$];
            text_char_t  c;
            mag = value[63] ? (~value + 64'd1) : value;
            // The loop body runs once for zero, which gives the single '0'.
            do begin
                digit_q.push_front(4'(mag % 64'd10));
                mag = mag / 64'd10;
            end while (mag != 64'd0);
            if (value[63]) begin
                c.ch   = ASCII_MINUS;
                c.last = 1'b0;
                expected_chars.push_back(c);
            end
            foreach (digit_q[i]) begin
                c.ch   = ASCII_ZERO + 8'(digit_q[i]);
                c.last = (i == digit_q.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        function void report(string what);
            failures++;
            if (failures <= MAX_REPORTED)
                $display("mismatch at %0t: %s", $realtime, what);
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            text_char_t want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected character 0x%02h last %0b", ch, last));
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch || last !== want.last)
                report($sformatf("expected 0x%02h last %0b, got 0x%02h last %0b",
                                 want.ch, want.last, ch, last));
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = 64'd0;   // [63:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] out_char
    logic        m_axis_tlast;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_off_go = 1'b0;
    int idle_cycles = 0;

    decimal_text_scoreboard sb = new();

    signed_binary_to_decimal_ascii dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Transfers are observed at the rising edge; the watchdog counts edges without any.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_value(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_char(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("signed_binary_to_decimal_ascii_tb failed");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : text_sink
        int stall_left;
        bit hold_off_done;
        stall_left    = 0;
        hold_off_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_go && !hold_off_done) begin
                hold_off_done = 1'b1;
                stall_left    = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Entered and left at a falling edge; tvalid stays high between back-to-back values.
    task automatic send_value(input logic [63:0] value);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    // Half are values of a random digit count, some at or just below a power of ten, some full width.
    function automatic logic [63:0] random_value();
        logic [63:0] mag;
        logic [63:0] pow10;
        int          kind;
        int          ndig;
        kind = $urandom_range(0, 9);
        if (kind < 3)
            return {$urandom, $urandom};
        ndig  = $urandom_range(1, 18);
        pow10 = 64'd1;
        repeat (ndig) pow10 = pow10 * 64'd10;
        if (kind < 5)
            mag = pow10 - 64'($urandom_range(0, 1));
        else
            mag = {$urandom, $urandom} % pow10;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    initial begin : stimulus
        logic [63:0] directed [22];
        directed = '{
            64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
            -64'd1000,
            64'h7FFF_FFFF_FFFF_FFFF,      // largest positive value
            64'h8000_0000_0000_0000,      // most negative value, magnitude taken unsigned
            64'h8000_0000_0000_0001,
            64'd1000000000000000000, -64'd1000000000000000000, 64'd999999999999999999,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'd1234567890, -64'd9876543210,
            64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        foreach (directed[i])
            send_value(directed[i]);

        for (int k = 0; k < RANDOM_VALUES; k++) begin
            if (k % 30 == 0) begin
                tx_idle_pct = pick_idle_pct();
                rx_idle_pct = pick_idle_pct();
            end
            if (k >= RANDOM_VALUES - QUIET_TAIL) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // The receiver holds off while values keep coming, so the input backs up.
            if (k == 40)
                hold_off_go = 1'b1;
            if (k == 100)
                pause_until_drained();
            send_value(random_value());
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("signed_binary_to_decimal_ascii_tb passed");
        else
            $display("signed_binary_to_decimal_ascii_tb failed");
        $finish;
    end

endmodule
